@@ rtl/qgsd_pkg.sv @@
// Package for the group-scaled q4 dot product core.
// Job record passed front to back, binary32 helpers for convert, multiply and add.
// No dependencies.
package qgsd_pkg;

	localparam logic [31:0] QNAN_DEFAULT = 32'hffc00000;
	localparam logic [31:0] QUIET_BIT    = 32'h00400000;

	typedef struct packed {
		logic [31:0] acc;
		logic [15:0] wsh;
		logic [31:0] asb;
		logic        do_group;
		logic        end_row;
	} qgsd_job_t;

	localparam int JOB_W = $bits(qgsd_job_t);

	typedef enum logic [3:0] {
		B_IDLE, B_CVT, B_MUL1, B_RND1, B_MUL2, B_RND2, B_ALN, B_NRM, B_EMIT
	} qgsd_bstate_t;

	typedef struct packed {
		logic               special;
		logic [31:0]        spec;
		logic               sign;
		logic signed [10:0] e;
		logic [47:0]        p;
	} qgsd_mul_t;

	typedef struct packed {
		logic        special;
		logic [31:0] spec;
		logic        sign;
		logic        zsign;
		logic [8:0]  e;
		logic [27:0] sum;
	} qgsd_add_t;

	function automatic logic is_nan(input logic [31:0] x);
		return (x[30:23] == 8'hff) && (x[22:0] != 23'd0);
	endfunction

	function automatic logic is_inf(input logic [31:0] x);
		return (x[30:23] == 8'hff) && (x[22:0] == 23'd0);
	endfunction

	function automatic logic [5:0] clz48(input logic [47:0] v);
		logic [5:0] n;
		logic       hit;
		n = 6'd48;
		hit = 1'b0;
		for (int i = 47; i >= 0; i--) begin
			if (!hit && v[i]) begin
				n = 6'(47 - i);
				hit = 1'b1;
			end
		end
		return n;
	endfunction

	function automatic logic [31:0] half_to_single(input logic [15:0] h);
		logic [10:0] m11;
		logic [5:0]  sh;
		logic [10:0] mn;
		logic [7:0]  ex;
		m11 = {1'b0, h[9:0]};
		sh = clz48({m11, 37'd0});
		mn = m11 << sh;
		ex = 8'd113 - 8'(sh);
		if (h[14:10] == 5'd0) begin
			if (h[9:0] == 10'd0) return {h[15], 31'd0};
			return {h[15], ex, mn[9:0], 13'd0};
		end
		if (h[14:10] == 5'h1f) return {h[15], 8'hff, h[9:0], 13'd0};
		return {h[15], 8'(h[14:10]) + 8'd112, h[9:0], 13'd0};
	endfunction

	function automatic logic [31:0] int_to_single(input logic [31:0] a);
		logic [31:0] m;
		logic [5:0]  lz;
		logic [31:0] n;
		m = a[31] ? (~a + 32'd1) : a;
		lz = clz48({m, 16'd0});
		n = m << lz;
		if (a == 32'd0) return 32'd0;
		return {a[31], 8'd158 - 8'(lz), n[30:8]};
	endfunction

	function automatic qgsd_mul_t fmul_pre(input logic [31:0] a, input logic [31:0] b);
		qgsd_mul_t  r;
		logic [7:0] ea, eb;
		logic [23:0] ma, mb;
		r.sign = a[31] ^ b[31];
		r.special = 1'b1;
		r.spec = {r.sign, 8'hff, 23'd0};
		if (is_nan(a)) r.spec = a | QUIET_BIT;
		else if (is_nan(b)) r.spec = b | QUIET_BIT;
		else if (is_inf(a)) begin
			if (b[30:0] == 31'd0) r.spec = QNAN_DEFAULT;
		end else if (is_inf(b)) begin
			if (a[30:0] == 31'd0) r.spec = QNAN_DEFAULT;
		end else r.special = 1'b0;
		ea = (a[30:23] == 8'd0) ? 8'd1 : a[30:23];
		eb = (b[30:23] == 8'd0) ? 8'd1 : b[30:23];
		ma = {a[30:23] != 8'd0, a[22:0]};
		mb = {b[30:23] != 8'd0, b[22:0]};
		r.e = $signed(11'(ea)) + $signed(11'(eb)) - 11'sd127;
		r.p = 48'(ma) * 48'(mb);
		return r;
	endfunction

	function automatic logic [31:0] fmul_post(input qgsd_mul_t s);
		logic [5:0]         lz;
		logic signed [10:0] er;
		logic signed [10:0] rs;
		logic [47:0]        n0, n, msk;
		logic               stk, g, st, inc;
		logic [7:0]         ef;
		logic [30:0]        res;
		lz = clz48(s.p);
		er = s.e + 11'sd1 - $signed(11'(lz));
		n0 = s.p << lz;
		n = n0;
		stk = 1'b0;
		ef = er[7:0];
		if (er < 11'sd1) begin
			rs = 11'sd1 - er;
			ef = 8'd0;
			if (rs >= 11'sd48) begin
				n = 48'd0;
				stk = 1'b1;
			end else begin
				msk = (48'd1 << rs[5:0]) - 48'd1;
				n = n0 >> rs[5:0];
				stk = |(n0 & msk);
			end
		end
		g = n[23];
		st = (|n[22:0]) | stk;
		inc = g & (st | n[24]);
		res = {ef, n[46:24]} + 31'(inc);
		if (s.special) return s.spec;
		if (s.p == 48'd0) return {s.sign, 31'd0};
		if (er >= 11'sd255) return {s.sign, 8'hff, 23'd0};
		return {s.sign, res};
	endfunction

	function automatic qgsd_add_t fadd_pre(input logic [31:0] a, input logic [31:0] b);
		qgsd_add_t   r;
		logic [31:0] x, y;
		logic [7:0]  ex, ey, d;
		logic [26:0] mx3, my3, ys, msk;
		logic        stk;
		r.special = 1'b1;
		r.spec = QNAN_DEFAULT;
		if (is_nan(a)) r.spec = a | QUIET_BIT;
		else if (is_nan(b)) r.spec = b | QUIET_BIT;
		else if (is_inf(a) && is_inf(b)) begin
			if (a[31] == b[31]) r.spec = a;
		end else if (is_inf(a)) r.spec = a;
		else if (is_inf(b)) r.spec = b;
		else r.special = 1'b0;
		if (a[30:0] < b[30:0]) begin
			x = b;
			y = a;
		end else begin
			x = a;
			y = b;
		end
		ex = (x[30:23] == 8'd0) ? 8'd1 : x[30:23];
		ey = (y[30:23] == 8'd0) ? 8'd1 : y[30:23];
		mx3 = {x[30:23] != 8'd0, x[22:0], 3'd0};
		my3 = {y[30:23] != 8'd0, y[22:0], 3'd0};
		d = ex - ey;
		if (d >= 8'd27) begin
			ys = 27'd0;
			stk = |my3;
		end else begin
			msk = (27'd1 << d[4:0]) - 27'd1;
			ys = my3 >> d[4:0];
			stk = |(my3 & msk);
		end
		ys[0] = ys[0] | stk;
		r.sum = (x[31] ^ y[31]) ? (28'(mx3) - 28'(ys)) : (28'(mx3) + 28'(ys));
		r.sign = x[31];
		r.zsign = a[31] & b[31];
		r.e = 9'(ex);
		return r;
	endfunction

	function automatic logic [31:0] fadd_post(input qgsd_add_t s);
		logic [26:0] n;
		logic [8:0]  e, s9, lz9;
		logic [5:0]  lz;
		logic [7:0]  ef;
		logic        g, st, inc;
		logic [30:0] res;
		lz = clz48({s.sum[26:0], 21'd0});
		lz9 = 9'(lz);
		if (s.sum[27]) begin
			n = {s.sum[27:2], s.sum[1] | s.sum[0]};
			e = s.e + 9'd1;
		end else begin
			s9 = (lz9 < s.e - 9'd1) ? lz9 : s.e - 9'd1;
			n = s.sum[26:0] << s9;
			e = s.e - s9;
		end
		ef = n[26] ? e[7:0] : 8'd0;
		g = n[2];
		st = |n[1:0];
		inc = g & (st | n[3]);
		res = {ef, n[25:3]} + 31'(inc);
		if (s.special) return s.spec;
		if (s.sum == 28'd0) return {s.zsign, 31'd0};
		if (e >= 9'd255) return {s.sign, 8'hff, 23'd0};
		return {s.sign, res};
	endfunction

endpackage

@@ rtl/qgsd_fifo.sv @@
// Small register queue between the front and back parts.
// Depends on nothing.
module qgsd_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  logic [WIDTH-1:0] wr_data,
	output logic             full,
	input  logic             rd_en,
	output logic [WIDTH-1:0] rd_data,
	output logic             empty
);
	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wp_q, rp_q;
	logic [CW-1:0]    cnt_q;
	logic             wr, rd;

	assign full = (cnt_q == CW'(DEPTH));
	assign empty = (cnt_q == '0);
	assign wr = wr_en & ~full;
	assign rd = rd_en & ~empty;
	assign rd_data = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (wr) mem_q[wp_q] <= wr_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			if (wr) wp_q <= (wp_q == PW'(DEPTH - 1)) ? '0 : wp_q + PW'(1);
			if (rd) rp_q <= (rp_q == PW'(DEPTH - 1)) ? '0 : rp_q + PW'(1);
			if (wr && !rd) cnt_q <= cnt_q + CW'(1);
			else if (rd && !wr) cnt_q <= cnt_q - CW'(1);
		end
	end
endmodule

@@ rtl/qgsd_front.sv @@
// Front part: per-beat int4 x int8 MAC into a saturating group accumulator.
// Issues a job at group or row end. Depends on qgsd_pkg.
module qgsd_front import qgsd_pkg::*; #(
	parameter int MAX_GROUP = 64
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              accept,
	input  logic [7:0]        weight_pair,
	input  logic signed [7:0] act_lo,
	input  logic signed [7:0] act_hi,
	input  logic [15:0]       weight_scale_half,
	input  logic [31:0]       act_scale_bits,
	input  logic              last_in_group,
	input  logic              last_in_row,
	output logic              job_push,
	output qgsd_job_t         job
);
	localparam int AW = $clog2(MAX_GROUP * 1024) + 2;
	localparam int SW = AW + 2;
	localparam logic signed [SW-1:0] LIMIT = SW'(MAX_GROUP * 1024);

	logic signed [AW-1:0] acc_q;
	logic signed [4:0]    w_lo, w_hi;
	logic signed [12:0]   p_lo, p_hi;
	logic signed [SW-1:0] sum, sat;

	always_comb begin
		w_lo = $signed({1'b0, weight_pair[3:0]}) - 5'sd8;
		w_hi = $signed({1'b0, weight_pair[7:4]}) - 5'sd8;
		p_lo = 13'(w_lo) * 13'(act_lo);
		p_hi = 13'(w_hi) * 13'(act_hi);
		sum = SW'(acc_q) + SW'(p_lo) + SW'(p_hi);
		if (sum > LIMIT) sat = LIMIT;
		else if (sum < -LIMIT) sat = -LIMIT;
		else sat = sum;
	end

	assign job_push = accept & (last_in_group | last_in_row);
	assign job.acc = 32'(sat);
	assign job.wsh = weight_scale_half;
	assign job.asb = act_scale_bits;
	assign job.do_group = last_in_group;
	assign job.end_row = last_in_row;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
		end else if (accept) begin
			acc_q <= (last_in_group || last_in_row) ? '0 : AW'(sat);
		end
	end
endmodule

@@ rtl/qgsd_back.sv @@
// Back part: float dequantize of a group and row sum, one binary32 step per cycle.
// Holds the result beat register. Depends on qgsd_pkg.
module qgsd_back import qgsd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        job_avail,
	input  qgsd_job_t   job,
	output logic        job_pop,
	output logic        empty,
	input  logic        pop,
	output logic [31:0] row_sum
);
	qgsd_bstate_t st_q, st_nxt;
	qgsd_job_t    job_q;
	logic [31:0]  a_q, ws_q, pr_q, row_q, out_q;
	qgsd_mul_t    mp_q;
	qgsd_add_t    ad_q;
	logic         out_valid_q, slot_free, res_push;

	assign slot_free = ~out_valid_q | pop;
	assign empty = ~out_valid_q;
	assign row_sum = out_q;

	always_comb begin
		st_nxt = st_q;
		unique case (st_q)
			B_IDLE: if (job_avail) st_nxt = job.do_group ? B_CVT : B_EMIT;
			B_CVT:  st_nxt = B_MUL1;
			B_MUL1: st_nxt = B_RND1;
			B_RND1: st_nxt = B_MUL2;
			B_MUL2: st_nxt = B_RND2;
			B_RND2: st_nxt = B_ALN;
			B_ALN:  st_nxt = B_NRM;
			B_NRM:  st_nxt = job_q.end_row ? B_EMIT : B_IDLE;
			B_EMIT: if (slot_free) st_nxt = B_IDLE;
			default: st_nxt = B_IDLE;
		endcase
	end

	always_comb begin
		job_pop = (st_q == B_IDLE) & job_avail;
		res_push = (st_q == B_EMIT) & slot_free;
	end

	always_ff @(posedge clk) begin
		if (job_pop) job_q <= job;
		case (st_q)
			B_CVT: begin
				a_q <= int_to_single(job_q.acc);
				ws_q <= half_to_single(job_q.wsh);
			end
			B_MUL1: mp_q <= fmul_pre(a_q, ws_q);
			B_RND1: pr_q <= fmul_post(mp_q);
			B_MUL2: mp_q <= fmul_pre(pr_q, job_q.asb);
			B_RND2: pr_q <= fmul_post(mp_q);
			B_ALN:  ad_q <= fadd_pre(row_q, pr_q);
			default: ;
		endcase
		if (res_push) out_q <= row_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= B_IDLE;
			row_q <= 32'd0;
			out_valid_q <= 1'b0;
		end else begin
			st_q <= st_nxt;
			if (st_q == B_NRM) row_q <= fadd_post(ad_q);
			else if (res_push) row_q <= 32'd0;
			if (res_push) out_valid_q <= 1'b1;
			else if (pop) out_valid_q <= 1'b0;
		end
	end
endmodule

@@ rtl/q4_group_scaled_dot_product_core.sv @@
// Top level of the q4 group-scaled dot product core.
// Depends on qgsd_pkg, qgsd_front, qgsd_fifo, qgsd_back.
//
// Usage:
//   Input queue: drive the beat fields and push; a beat is taken when push is
//   high and full is low. Each beat adds two int4 x int8 products into the
//   group accumulator.
//   A beat with last_in_group or last_in_row becomes a job in a JOB_DEPTH entry
//   queue. The float unit runs convert, two multiplies with separate rounding
//   and add for each closed group, then an emit step at row end.
//   Throughput is one beat per cycle while the job queue has room; short groups
//   can fill it, and full rises when the job queue fills.
//   Result queue: row_sum is valid while empty is low and is taken with pop.
//   After the last beat of a row, empty falls once its job has passed the job
//   queue and back part; a row ending inside a group skips the float steps.
//   If the result is not popped, the back part holds at row end and the job
//   queue, then full, backs up; no beat is lost.
//   Reset clears the group accumulator, the row sum and both queues.
module q4_group_scaled_dot_product_core import qgsd_pkg::*; #(
	parameter int MAX_GROUP = 64,
	parameter int JOB_DEPTH = 4
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	output logic              full,
	input  logic [7:0]        weight_pair,
	input  logic signed [7:0] act_lo,
	input  logic signed [7:0] act_hi,
	input  logic [15:0]       weight_scale_half,
	input  logic [31:0]       act_scale_bits,
	input  logic              last_in_group,
	input  logic              last_in_row,
	output logic              empty,
	input  logic              pop,
	output logic [31:0]       row_sum
);
	logic      job_push, job_pop, job_empty;
	qgsd_job_t job_in, job_out;
	logic [JOB_W-1:0] job_rd;

	qgsd_front #(.MAX_GROUP(MAX_GROUP)) u_front (
		.clk(clk), .arst_n(arst_n), .accept(push & ~full),
		.weight_pair(weight_pair), .act_lo(act_lo), .act_hi(act_hi),
		.weight_scale_half(weight_scale_half), .act_scale_bits(act_scale_bits),
		.last_in_group(last_in_group), .last_in_row(last_in_row),
		.job_push(job_push), .job(job_in)
	);

	qgsd_fifo #(.WIDTH(JOB_W), .DEPTH(JOB_DEPTH)) u_fifo (
		.clk(clk), .arst_n(arst_n),
		.wr_en(job_push), .wr_data(job_in), .full(full),
		.rd_en(job_pop), .rd_data(job_rd), .empty(job_empty)
	);

	assign job_out = qgsd_job_t'(job_rd);

	qgsd_back u_back (
		.clk(clk), .arst_n(arst_n),
		.job_avail(~job_empty), .job(job_out), .job_pop(job_pop),
		.empty(empty), .pop(pop), .row_sum(row_sum)
	);
endmodule

@@ tb/tb_q4_group_scaled_dot_product_core.sv @@
// Testbench for q4_group_scaled_dot_product_core: directed table, then random rows.
// Checks each row_sum against table sums or this file's bit-exact binary32 predictor.
// Depends on the RTL top level and qgsd_pkg (compiled with it).
module tb_q4_group_scaled_dot_product_core;

	localparam int GROUP_SAT   = 64 * 1024;
	localparam int N_RANDOM    = 1850;
	localparam int IDLE_LIMIT  = 4000;
	localparam int DRAIN_WAIT  = 40;
	localparam logic [31:0] NAN_DFLT = 32'hffc00000;
	localparam logic [31:0] QBIT     = 32'h00400000;

	typedef struct {
		logic [7:0]        wp;
		logic signed [7:0] al;
		logic signed [7:0] ah;
		logic [15:0]       wsh;
		logic [31:0]       asb;
		logic              lig;
		logic              lir;
		logic              known;
		logic [31:0]       sum;
	} beat_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              push = 1'b0;
	logic              full;
	logic [7:0]        weight_pair = '0;
	logic signed [7:0] act_lo = '0;
	logic signed [7:0] act_hi = '0;
	logic [15:0]       weight_scale_half = '0;
	logic [31:0]       act_scale_bits = '0;
	logic              last_in_group = 1'b0;
	logic              last_in_row = 1'b0;
	logic              empty;
	logic              pop = 1'b0;
	logic [31:0]       row_sum;

	q4_group_scaled_dot_product_core u_top (.*);

	always #6 clk = ~clk;

	beat_t       cur;
	beat_t       dir_tbl[$];
	logic [31:0] sum_q[$];
	int          grp_acc = 0;
	logic [31:0] row_acc = 32'd0;
	int          in_cnt, out_cnt, errors, idle;
	bit          sender_burst;

	function automatic logic [31:0] round_pack(bit sgn, longint unsigned m, int x);
		int              k, e, q, sh;
		longint unsigned r, rem, half;
		longint          bits;
		k = 63;
		while (!m[k]) k--;
		e = x + k;
		q = (e - 23 > -149) ? e - 23 : -149;
		sh = q - x;
		rem = 0;
		half = 1;
		if (sh <= 0) begin
			r = m << (-sh);
		end else if (sh >= 65) begin
			r = 0;
		end else if (sh == 64) begin
			r = 0;
			rem = m;
			half = 64'h8000000000000000;
		end else begin
			r = m >> sh;
			rem = m & ((64'd1 << sh) - 1);
			half = 64'd1 << (sh - 1);
		end
		if (sh > 0 && (rem > half || (rem == half && r[0]))) r++;
		bits = (longint'(q + 149) << 23) + longint'(r);
		if (bits >= 64'h7f800000) return {sgn, 8'hff, 23'd0};
		return {sgn, bits[30:0]};
	endfunction

	function automatic bit nan32(logic [31:0] v);
		return v[30:23] == 8'hff && v[22:0] != 0;
	endfunction

	function automatic bit inf32(logic [31:0] v);
		return v[30:23] == 8'hff && v[22:0] == 0;
	endfunction

	function automatic logic [31:0] half_bits_to_single(logic [15:0] h);
		if (h[14:10] == 0) begin
			if (h[9:0] == 0) return {h[15], 31'd0};
			return round_pack(h[15], h[9:0], -24);
		end
		if (h[14:10] == 5'h1f) return {h[15], 8'hff, h[9:0], 13'd0};
		return {h[15], 8'(h[14:10]) + 8'd112, h[9:0], 13'd0};
	endfunction

	function automatic logic [31:0] fp_mul(logic [31:0] a, logic [31:0] b);
		bit sgn;
		int ea, eb;
		longint unsigned ma, mb;
		sgn = a[31] ^ b[31];
		if (nan32(a)) return a | QBIT;
		if (nan32(b)) return b | QBIT;
		if (inf32(a)) return (b[30:0] == 0) ? NAN_DFLT : {sgn, 8'hff, 23'd0};
		if (inf32(b)) return (a[30:0] == 0) ? NAN_DFLT : {sgn, 8'hff, 23'd0};
		if (a[30:0] == 0 || b[30:0] == 0) return {sgn, 31'd0};
		ea = (a[30:23] == 0) ? 1 : a[30:23];
		eb = (b[30:23] == 0) ? 1 : b[30:23];
		ma = {a[30:23] != 0, a[22:0]};
		mb = {b[30:23] != 0, b[22:0]};
		return round_pack(sgn, ma * mb, ea + eb - 300);
	endfunction

	function automatic logic [31:0] fp_add(logic [31:0] a, logic [31:0] b);
		logic [31:0]     x, y;
		int              ex, ey, d, xe;
		longint unsigned mx, my, big, lil, s;
		if (nan32(a)) return a | QBIT;
		if (nan32(b)) return b | QBIT;
		if (inf32(a) && inf32(b)) return (a[31] == b[31]) ? a : NAN_DFLT;
		if (inf32(a)) return a;
		if (inf32(b)) return b;
		if (a[30:0] == 0 && b[30:0] == 0) return {a[31] & b[31], 31'd0};
		if (a[30:0] < b[30:0]) begin
			x = b;
			y = a;
		end else begin
			x = a;
			y = b;
		end
		ex = (x[30:23] == 0) ? 1 : x[30:23];
		ey = (y[30:23] == 0) ? 1 : y[30:23];
		mx = {x[30:23] != 0, x[22:0]};
		my = {y[30:23] != 0, y[22:0]};
		d = ex - ey;
		if (d >= 38) begin
			big = mx << 38;
			lil = (my != 0) ? 1 : 0;
			xe = ex - 150 - 38;
		end else begin
			big = mx << d;
			lil = my;
			xe = ey - 150;
		end
		s = (x[31] == y[31]) ? big + lil : big - lil;
		if (s == 0) return 32'd0;
		return round_pack(x[31], s, xe);
	endfunction

	// advance the dot product state by one beat; returns 1 when a row_sum is due
	function automatic bit dot_step(beat_t b, output logic [31:0] sum);
		int          lo, hi, acc;
		logic [31:0] af, p;
		lo = int'(b.wp[3:0]) - 8;
		hi = int'(b.wp[7:4]) - 8;
		acc = grp_acc + lo * int'(b.al) + hi * int'(b.ah);
		if (acc > GROUP_SAT) acc = GROUP_SAT;
		if (acc < -GROUP_SAT) acc = -GROUP_SAT;
		grp_acc = acc;
		if (b.lig) begin
			af = (acc == 0) ? 32'd0 : round_pack(acc < 0, (acc < 0) ? -acc : acc, 0);
			p = fp_mul(fp_mul(af, half_bits_to_single(b.wsh)), b.asb);
			row_acc = fp_add(row_acc, p);
			grp_acc = 0;
		end
		sum = row_acc;
		if (b.lir) begin
			row_acc = 0;
			grp_acc = 0;
		end
		return b.lir;
	endfunction

	always @(posedge clk) begin
		logic [31:0] s, want;
		beat_t       b;
		if (push && !full) begin
			b = '{weight_pair, act_lo, act_hi, weight_scale_half, act_scale_bits,
				last_in_group, last_in_row, cur.known, cur.sum};
			if (dot_step(b, s)) sum_q.push_back(b.known ? b.sum : s);
			in_cnt++;
		end
		if (pop && !empty) begin
			out_cnt++;
			if (sum_q.size() == 0) begin
				errors++;
				if (errors <= 10) $display("unexpected row_sum beat %h", row_sum);
			end else begin
				want = sum_q.pop_front();
				if (row_sum !== want) begin
					errors++;
					if (errors <= 10)
						$display("row_sum: expected %h got %h", want, row_sum);
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((push && !full) || (pop && !empty)) idle = 0;
		else idle++;
		if (idle >= IDLE_LIMIT) begin
			$display("q4_group_scaled_dot_product_core: mismatch");
			$finish;
		end
	end

	task automatic send(beat_t b);
		int n, gap;
		gap = sender_burst ? 0 : $urandom_range(0, 10);
		repeat (gap) begin
			@(negedge clk);
			push = 1'b0;
		end
		@(negedge clk);
		cur = b;
		weight_pair = b.wp;
		act_lo = b.al;
		act_hi = b.ah;
		weight_scale_half = b.wsh;
		act_scale_bits = b.asb;
		last_in_group = b.lig;
		last_in_row = b.lir;
		push = 1'b1;
		n = in_cnt;
		do @(negedge clk); while (in_cnt == n);
		push = 1'b0;
	endtask

	task automatic add_dir(logic [7:0] wp, logic signed [7:0] al, logic signed [7:0] ah,
			logic [15:0] wsh, logic [31:0] asb, logic lig, logic lir, logic known,
			logic [31:0] sum);
		dir_tbl.push_back('{wp, al, ah, wsh, asb, lig, lir, known, sum});
	endtask

	function automatic logic [15:0] pick_half();
		if ($urandom_range(0, 7) == 0) return 16'($urandom);
		return {1'($urandom), 5'($urandom_range(10, 20)), 10'($urandom)};
	endfunction

	function automatic logic [31:0] pick_single();
		if ($urandom_range(0, 7) == 0) return $urandom;
		return {1'($urandom), 8'($urandom_range(110, 140)), 23'($urandom)};
	endfunction

	initial begin
		int n, rows, ng, len, cut;
		bit heavy, pressed;
		beat_t b;
		repeat (9) @(negedge clk);
		arst_n = 1'b1;

		add_dir(8'hff, 127, 127, 16'h3c00, 32'h3f800000, 1, 1, 1, 32'h44de4000);
		add_dir(8'h00, -128, -128, 16'h3c00, 32'h3f800000, 1, 1, 1, 32'h45000000);
		add_dir(8'h9a, 100, -50, 16'h3c00, 32'h3f800000, 0, 1, 1, 32'h00000000);
		add_dir(8'h88, 33, 77, 16'h7c00, 32'h3f800000, 1, 1, 1, NAN_DFLT);
		add_dir(8'hf0, 127, -128, 16'h0000, 32'h3f800000, 1, 1, 0, 0);
		add_dir(8'h3c, -7, 19, 16'h8000, 32'h40000000, 1, 1, 0, 0);
		add_dir(8'h5a, 11, 99, 16'h0001, 32'h3f800000, 1, 1, 0, 0);
		add_dir(8'ha5, -99, 3, 16'h83ff, 32'h3f000000, 1, 1, 0, 0);
		add_dir(8'hff, 127, 127, 16'h7c00, 32'h3f800000, 1, 1, 0, 0);
		add_dir(8'h01, 1, 1, 16'hfc00, 32'h3f800000, 1, 1, 0, 0);
		add_dir(8'h12, 5, 6, 16'h7e01, 32'h3f800000, 1, 1, 0, 0);
		add_dir(8'h7f, 127, -1, 16'h7bff, 32'h7f7fffff, 1, 1, 0, 0);
		add_dir(8'h44, 20, 20, 16'h3c00, 32'h7f800000, 1, 1, 0, 0);
		add_dir(8'h44, 20, 20, 16'h3c00, 32'h7fa00000, 1, 1, 0, 0);
		add_dir(8'hc3, -5, 8, 16'h3c00, 32'h00000001, 1, 1, 0, 0);
		add_dir(8'he1, 60, -60, 16'h4248, 32'hff7fffff, 1, 0, 0, 0);
		add_dir(8'h2d, -30, 90, 16'hffff, 32'hffffffff, 0, 0, 0, 0);
		add_dir(8'h6b, 14, -14, 16'h3555, 32'hbf800000, 1, 1, 0, 0);
		add_dir(8'hb7, 127, 127, 16'h3800, 32'h3e800000, 1, 0, 0, 0);
		add_dir(8'h4e, -128, 1, 16'hc000, 32'h3f800000, 1, 1, 0, 0);
		foreach (dir_tbl[i]) send(dir_tbl[i]);

		n = 0;
		rows = 0;
		pressed = 0;
		while (n < N_RANDOM) begin
			if ($urandom_range(0, 4) == 0) sender_burst = !sender_burst;
			if (!pressed && rows == 40) begin
				pressed = 1;
				while (sum_q.size() != 0) @(negedge clk);
			end
			ng = $urandom_range(1, 4);
			cut = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 4) : 0;
			for (int g = 0; g < ng; g++) begin
				heavy = ($urandom_range(0, 14) == 0);
				len = heavy ? $urandom_range(60, 100) : $urandom_range(1, 12);
				for (int k = 0; k < len; k++) begin
					b.wp = $urandom;
					b.al = $urandom;
					b.ah = $urandom;
					if (heavy && $urandom_range(0, 3) != 0) begin
						b.wp = (g % 2) ? 8'h00 : 8'hff;
						b.al = (g % 2) ? -128 : 127;
						b.ah = b.al;
					end
					b.wsh = pick_half();
					b.asb = pick_single();
					b.lig = (k == len - 1);
					b.lir = (g == ng - 1) && b.lig;
					b.known = 0;
					b.sum = 0;
					if (cut != 0 && g == ng - 1 && k == cut - 1 && k < len - 1) begin
						b.lir = 1;
						k = len;
					end
					send(b);
					n++;
				end
			end
			rows++;
		end
		while (sum_q.size() != 0) @(negedge clk);
		repeat (DRAIN_WAIT) @(negedge clk);
		if (errors == 0) $display("q4_group_scaled_dot_product_core: match");
		else $display("q4_group_scaled_dot_product_core: mismatch");
		$finish;
	end

	initial begin
		int gap, n;
		bit calm;
		calm = 0;
		@(posedge arst_n);
		forever begin
			if ($urandom_range(0, 9) == 0) calm = !calm;
			gap = calm ? 0 : $urandom_range(0, 10);
			repeat (gap) begin
				@(negedge clk);
				pop = 1'b0;
			end
			@(negedge clk);
			pop = 1'b1;
			n = out_cnt;
			do @(negedge clk); while (out_cnt == n);
			pop = 1'b0;
		end
	end

endmodule

@@ sim.f @@
rtl/qgsd_pkg.sv
rtl/qgsd_fifo.sv
rtl/qgsd_front.sv
rtl/qgsd_back.sv
rtl/q4_group_scaled_dot_product_core.sv
tb/tb_q4_group_scaled_dot_product_core.sv
